/* rtl/fme_pkg.sv */
// ----------------------------------------------------------------------------
// fme_pkg
// Shared types, constants and table builders for the fuzzy membership
// evaluator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fme_pkg;

  // Field widths and shape constants.
  localparam int VALUE_BITS      = 16;
  localparam int DEGREE_BITS     = 16;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int EXP_FRAC_BITS   = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_ARG_LIMIT   = 24;
  localparam int GAUSS_FRAC      = 12;
  localparam int SERIES_TERMS    = 20;
  localparam int ONE_SHIFT       = 30;

  // Internal datapath widths.
  localparam int DIFF_W  = VALUE_BITS + 1;
  localparam int WIDE_W  = VALUE_BITS + 6;
  localparam int AN_W    = VALUE_BITS + 5;
  localparam int RAMP_W  = VALUE_BITS + DEGREE_BITS;
  localparam int NUM1_W  = AN_W + GAUSS_FRAC;
  localparam int DEN1_W  = VALUE_BITS;
  localparam int Q1_W    = VALUE_BITS + 1;
  localparam int ARG_LIM = EXP_ARG_LIMIT * EXP_TABLE_DEPTH;
  localparam int ARG_W   = $clog2(ARG_LIM + 1);
  localparam int K_W     = ARG_W - EXP_FRAC_BITS;
  localparam int TQ_MAX  = 8 << GAUSS_FRAC;
  localparam int TQ_W    = $clog2(TQ_MAX + 1);
  localparam int SQ_W    = 2 * TQ_W;
  localparam int YQ_SHIFT = 2 * GAUSS_FRAC + 1 - EXP_FRAC_BITS;
  localparam int E_W     = ONE_SHIFT + 1;
  localparam int PROD_W  = E_W + DEGREE_BITS;
  localparam int DEN2_W  = E_W + 1;
  localparam int NUM2_W  = PROD_W;

  // Degree constants.
  localparam longint unsigned DMAX_L = (64'd1 << DEGREE_BITS) - 64'd1;
  localparam logic [DEGREE_BITS-1:0] DMAX = DEGREE_BITS'(DMAX_L);
  localparam logic [DEGREE_BITS-1:0] THRESH =
    DEGREE_BITS'((64'd9999 * DMAX_L + 64'd9999) / 64'd10000);
  localparam logic [DEGREE_BITS-1:0] NOT_LOW = DEGREE_BITS'((DMAX_L + 64'd5000) / 64'd10000);
  localparam logic [DEGREE_BITS-1:0] FLOOR = DEGREE_BITS'((DMAX_L + 64'd99999) / 64'd100000);
  localparam logic [E_W-1:0] ONE_Q30 = E_W'(64'd1 << ONE_SHIFT);
  localparam logic [NUM2_W-1:0] ONE_DMAX = NUM2_W'((64'd1 << ONE_SHIFT) * DMAX_L);

  // Shape codes.
  typedef enum logic [2:0] {
    SHAPE_LEFT  = 3'd0,
    SHAPE_RIGHT = 3'd1,
    SHAPE_TRI   = 3'd2,
    SHAPE_SIG   = 3'd3,
    SHAPE_RSIG  = 3'd4,
    SHAPE_GAUSS = 3'd5
  } shape_t;

  // Status codes.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_DOMAIN     = 2'd1,
    STAT_ZERO_WIDTH = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SHAPE_KIND  = 2'd0,
    REG_START_POINT = 2'd1,
    REG_END_POINT   = 2'd2
  } cfg_reg_t;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    shape_t  kind;
    status_t status;
    logic    sup;
    logic    full;
    logic    neg;
  } ctl_t;

  typedef struct packed {
    ctl_t                   ctl;
    logic [DEGREE_BITS-1:0] ramp_deg;
    logic [DEGREE_BITS-1:0] gauss_deg;
  } side_t;

  typedef logic [E_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Quotient of a dividend below 2^(ONE_SHIFT+1) by a small divisor, by
  // shift and subtract.
  function automatic longint unsigned div_small(input longint unsigned n,
                                                input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = ONE_SHIFT; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Truncated Taylor series of exp(-u), u in Q30 with 0 <= u <= 1.0.
  function automatic logic [E_W-1:0] exp_series(input longint unsigned u);
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    term = 64'd1 << ONE_SHIFT;
    pos  = term;
    neg  = 64'd0;
    for (int i = 1; i <= SERIES_TERMS; i++) begin
      term = div_small((term * u) >> ONE_SHIFT, 64'(i));
      if ((i % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? E_W'(pos - neg) : '0;
  endfunction

  // exp(-r/EXP_TABLE_DEPTH) for every fractional step r.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    for (int r = 0; r < EXP_TABLE_DEPTH; r++) begin
      rom[r] = exp_series(longint'(r) << (ONE_SHIFT - EXP_FRAC_BITS));
    end
    return rom;
  endfunction

  localparam logic [E_W-1:0] E_ONE = exp_series(64'd1 << ONE_SHIFT);

  function automatic logic [DEGREE_BITS-1:0] floor_deg(input logic [DEGREE_BITS-1:0] v);
    return (v < FLOOR) ? FLOOR : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/fme_div.sv */
// ----------------------------------------------------------------------------
// fme_div
// Pipelined restoring divider, one quotient bit per stage. Quotients that do
// not fit in Q_W bits come out as all ones. A tag rides along with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16,
  parameter int Q_W   = 17,
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [TAG_W-1:0] tag_in,
  output logic                  out_valid,
  output logic [Q_W-1:0]        quo,
  output logic [TAG_W-1:0]      tag_out
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [Q_W:0]       vld;
  logic [DEN_W-1:0]   rem       [Q_W+1];
  logic [DEN_W-1:0]   rem_next  [Q_W+1];
  logic [Q_W-1:0]     nlo       [Q_W+1];
  logic [Q_W-1:0]     nlo_next  [Q_W+1];
  logic [DEN_W-1:0]   dv        [Q_W+1];
  logic [DEN_W-1:0]   dv_next   [Q_W+1];
  logic [Q_W-1:0]     qacc      [Q_W+1];
  logic [Q_W-1:0]     qacc_next [Q_W+1];
  logic               ovf       [Q_W+1];
  logic               ovf_next  [Q_W+1];
  logic [TAG_W-1:0]   tg        [Q_W+1];
  logic [TAG_W-1:0]   tg_next   [Q_W+1];

  // Stage zero checks for overflow; each later stage resolves one bit.
  always_comb begin
    logic [HI_W-1:0]  hi;
    logic [DEN_W:0]   trial;
    logic             ge;
    hi           = num[NUM_W-1:Q_W];
    rem_next[0]  = DEN_W'(hi);
    ovf_next[0]  = CMP_W'(hi) >= CMP_W'(den);
    nlo_next[0]  = num[Q_W-1:0];
    dv_next[0]   = den;
    qacc_next[0] = '0;
    tg_next[0]   = tag_in;
    for (int i = 1; i <= Q_W; i++) begin
      trial = {rem[i-1], nlo[i-1][Q_W-i]};
      ge    = trial >= {1'b0, dv[i-1]};
      rem_next[i]  = ge ? DEN_W'(trial - {1'b0, dv[i-1]}) : DEN_W'(trial);
      qacc_next[i] = qacc[i-1];
      qacc_next[i][Q_W-i] = ge;
      nlo_next[i]  = nlo[i-1];
      dv_next[i]   = dv[i-1];
      ovf_next[i]  = ovf[i-1];
      tg_next[i]   = tg[i-1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Q_W-1:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    rem  <= rem_next;
    nlo  <= nlo_next;
    dv   <= dv_next;
    qacc <= qacc_next;
    ovf  <= ovf_next;
    tg   <= tg_next;
  end

  assign out_valid = vld[Q_W];
  assign quo       = ovf[Q_W] ? '1 : qacc[Q_W];
  assign tag_out   = tg[Q_W];

endmodule

`default_nettype wire

/* rtl/fme_prep.sv */
// ----------------------------------------------------------------------------
// fme_prep
// Front end: captures the input value with the shape setup, classifies the
// value against the shape and forms the numerator and denominator of the
// main division.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_prep import fme_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic signed [VALUE_BITS-1:0]  x_value,
  input  wire shape_t                        shape_kind,
  input  wire logic signed [VALUE_BITS-1:0]  start_point,
  input  wire logic signed [VALUE_BITS-1:0]  end_point,
  output logic                               out_valid,
  output logic [NUM1_W-1:0]                  num,
  output logic [DEN1_W-1:0]                  den,
  output side_t                              side
);

  // Stage 1: capture.
  logic                           v1;
  logic signed [VALUE_BITS-1:0]   x1;
  logic signed [VALUE_BITS-1:0]   s1;
  logic signed [VALUE_BITS-1:0]   e1;
  shape_t                         k1;

  // Stage 2: differences.
  logic                       v2;
  logic signed [DIFF_W-1:0]   w2;
  logic signed [DIFF_W-1:0]   dx2;
  logic signed [DIFF_W-1:0]   de2;
  shape_t                     k2;

  // Stage 3: classification and operands.
  logic                v3;
  logic [AN_W-1:0]     an3;
  logic [DEN1_W-1:0]   aw3;
  ctl_t                ctl3;
  logic [AN_W-1:0]     an_next;
  logic [DEN1_W-1:0]   aw_next;
  ctl_t                ctl_next;

  // Stage 4 next values.
  logic [NUM1_W-1:0]   num_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // Capture the value together with the shape it is measured against.
  always_ff @(posedge clk) begin
    x1 <= x_value;
    s1 <= start_point;
    e1 <= end_point;
    k1 <= shape_kind;
  end

  // Width, offset from the start and distance to the end.
  always_ff @(posedge clk) begin
    w2  <= DIFF_W'(e1) - DIFF_W'(s1);
    dx2 <= DIFF_W'(x1) - DIFF_W'(s1);
    de2 <= DIFF_W'(e1) - DIFF_W'(x1);
    k2  <= k1;
  end

  // Domain checks and the dividend operand for each shape.
  always_comb begin
    logic                      dx_pos;
    logic                      de_pos;
    logic signed [DIFF_W:0]    dx_dbl;
    logic signed [DIFF_W:0]    de_dbl;
    logic signed [WIDE_W-1:0]  sw;
    logic signed [WIDE_W-1:0]  sdx;
    logic signed [WIDE_W-1:0]  sig_n;
    logic signed [WIDE_W-1:0]  gau_n;
    logic signed [WIDE_W-1:0]  sig_abs;
    logic signed [WIDE_W-1:0]  gau_abs;
    logic signed [DIFF_W-1:0]  w_abs;
    dx_pos  = dx2 > 0;
    de_pos  = de2 > 0;
    dx_dbl  = {dx2, 1'b0};
    de_dbl  = {de2, 1'b0};
    sw      = WIDE_W'(w2);
    sdx     = WIDE_W'(dx2);
    sig_n   = (sw <<< 2) + (sw <<< 1) - (sdx <<< 3) - (sdx <<< 2);
    gau_n   = (sdx <<< 3) - (sw <<< 2);
    sig_abs = sig_n[WIDE_W-1] ? -sig_n : sig_n;
    gau_abs = gau_n[WIDE_W-1] ? -gau_n : gau_n;
    w_abs   = w2[DIFF_W-1] ? -w2 : w2;

    ctl_next        = '0;
    ctl_next.kind   = k2;
    ctl_next.status = STAT_OK;
    an_next         = '0;
    aw_next         = w_abs[DEN1_W-1:0];

    case (k2) inside
      SHAPE_LEFT: begin
        ctl_next.sup = de_pos;
        if (!de_pos) begin
          ctl_next.status = STAT_DOMAIN;
        end else if (!dx_pos) begin
          ctl_next.full = 1'b1;
        end else begin
          an_next = AN_W'(de2[VALUE_BITS-1:0]);
        end
      end
      SHAPE_RIGHT: begin
        ctl_next.sup = dx_pos;
        if (!dx_pos) begin
          ctl_next.status = STAT_DOMAIN;
        end else if (!de_pos) begin
          ctl_next.full = 1'b1;
        end else begin
          an_next = AN_W'(dx2[VALUE_BITS-1:0]);
        end
      end
      SHAPE_TRI: begin
        ctl_next.sup = dx_pos && de_pos;
        if (!(dx_pos && de_pos)) begin
          ctl_next.status = STAT_DOMAIN;
        end else if (dx_dbl <= (DIFF_W + 1)'(w2)) begin
          an_next = AN_W'(dx_dbl[VALUE_BITS-1:0]);
        end else begin
          an_next = AN_W'(de_dbl[VALUE_BITS-1:0]);
        end
      end
      SHAPE_SIG, SHAPE_RSIG: begin
        ctl_next.sup = 1'b1;
        ctl_next.neg = sig_n[WIDE_W-1] != w2[DIFF_W-1];
        an_next      = sig_abs[AN_W-1:0];
        if (w2 == 0) begin
          ctl_next.status = STAT_ZERO_WIDTH;
        end
      end
      SHAPE_GAUSS: begin
        ctl_next.sup = 1'b1;
        an_next      = gau_abs[AN_W-1:0];
        if (w2 == 0) begin
          ctl_next.status = STAT_ZERO_WIDTH;
        end
      end
      default: begin
        ctl_next.status = STAT_ZERO_WIDTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    an3  <= an_next;
    aw3  <= aw_next;
    ctl3 <= ctl_next;
  end

  // Scale the dividend and add half the divisor for rounding.
  always_comb begin
    logic [RAMP_W-1:0] ramp_prod;
    logic [NUM1_W-1:0] half;
    ramp_prod = RAMP_W'(an3[VALUE_BITS-1:0]) * RAMP_W'(DMAX);
    half      = NUM1_W'(aw3 >> 1);
    case (ctl3.kind) inside
      SHAPE_LEFT, SHAPE_RIGHT, SHAPE_TRI: num_next = NUM1_W'(ramp_prod) + half;
      SHAPE_SIG, SHAPE_RSIG: num_next = (NUM1_W'(an3) << EXP_FRAC_BITS) + half;
      SHAPE_GAUSS: num_next = (NUM1_W'(an3) << GAUSS_FRAC) + half;
      default: num_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    num            <= num_next;
    den            <= aw3;
    side.ctl       <= ctl3;
    side.ramp_deg  <= '0;
    side.gauss_deg <= '0;
  end

endmodule

`default_nettype wire

/* rtl/fme_exp.sv */
// ----------------------------------------------------------------------------
// fme_exp
// Exponent unit: turns the main quotient into the quantized exponent
// argument, reads exp(-fraction) from a table and multiplies by exp(-1) once
// per whole unit along a chain of pipelined multiplier stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_exp import fme_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [Q1_W-1:0] quo,
  input  wire side_t           side_in,
  output logic                 out_valid,
  output logic [E_W-1:0]       e_out,
  output side_t                side_out
);

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  logic              vg1;
  logic              vg2;
  logic              vg3;
  logic              vrom;
  logic [ARG_W-1:0]  zq1;
  logic [TQ_W-1:0]   tq1;
  side_t             sd1;
  side_t             sd1_next;
  logic [ARG_W-1:0]  zq2;
  logic [SQ_W-1:0]   sq2;
  side_t             sd2;
  logic [ARG_W-1:0]  arg3;
  side_t             sd3;
  logic [ARG_W-1:0]  arg_next;

  logic [EXP_ARG_LIMIT-1:0] vc;
  logic [E_W-1:0]         ev      [EXP_ARG_LIMIT+1];
  logic [E_W-1:0]         ev_next [EXP_ARG_LIMIT+1];
  logic [K_W-1:0]         kv      [EXP_ARG_LIMIT+1];
  side_t                  sv      [EXP_ARG_LIMIT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vg1  <= 1'b0;
      vg2  <= 1'b0;
      vg3  <= 1'b0;
      vrom <= 1'b0;
      vc   <= '0;
    end else begin
      vg1  <= in_valid;
      vg2  <= vg1;
      vg3  <= vg2;
      vrom <= vg3;
      vc   <= {vc[EXP_ARG_LIMIT-2:0], vrom};
    end
  end

  // The ramp degree is settled here: full scale or the rounded quotient.
  always_comb begin
    sd1_next          = side_in;
    sd1_next.ramp_deg = side_in.ctl.full ? DMAX : quo[DEGREE_BITS-1:0];
  end

  // Clamp the quotient for the sigmoid and Gaussian arguments.
  always_ff @(posedge clk) begin
    zq1 <= (quo > Q1_W'(ARG_LIM)) ? ARG_W'(ARG_LIM) : ARG_W'(quo);
    tq1 <= (quo > Q1_W'(TQ_MAX)) ? TQ_W'(TQ_MAX) : TQ_W'(quo);
    sd1 <= sd1_next;
  end

  // Square of the Gaussian distance.
  always_ff @(posedge clk) begin
    zq2 <= zq1;
    sq2 <= SQ_W'(tq1) * SQ_W'(tq1);
    sd2 <= sd1;
  end

  // Gaussian: half the square, rounded into exponent steps, then clamped; other shapes keep the clamped quotient.
  always_comb begin
    logic [SQ_W-1:0] yq;
    yq = (sq2 + (SQ_W'(1) << (YQ_SHIFT - 1))) >> YQ_SHIFT;
    if (sd2.ctl.kind == SHAPE_GAUSS) begin
      arg_next = (yq > SQ_W'(ARG_LIM)) ? ARG_W'(ARG_LIM) : ARG_W'(yq);
    end else begin
      arg_next = zq2;
    end
  end

  always_ff @(posedge clk) begin
    arg3 <= arg_next;
    sd3  <= sd2;
  end

  // Multiplier chain: stage j applies exp(-1) when the whole part exceeds j.
  always_comb begin
    ev_next[0] = ev[0];
    for (int j = 0; j < EXP_ARG_LIMIT; j++) begin
      if (kv[j] > K_W'(j)) begin
        ev_next[j+1] = E_W'(((2 * E_W)'(ev[j]) * (2 * E_W)'(E_ONE)) >> ONE_SHIFT);
      end else begin
        ev_next[j+1] = ev[j];
      end
    end
  end

  // Table read of the fractional part, then the chain registers.
  always_ff @(posedge clk) begin
    ev[0] <= EXP_ROM[arg3[EXP_FRAC_BITS-1:0]];
    kv[0] <= arg3[ARG_W-1:EXP_FRAC_BITS];
    sv[0] <= sd3;
    for (int j = 1; j <= EXP_ARG_LIMIT; j++) begin
      ev[j] <= ev_next[j];
      kv[j] <= kv[j-1];
      sv[j] <= sv[j-1];
    end
  end

  assign out_valid = vc[EXP_ARG_LIMIT-1];
  assign e_out     = ev[EXP_ARG_LIMIT];
  assign side_out  = sv[EXP_ARG_LIMIT];

endmodule

`default_nettype wire

/* rtl/fme_post.sv */
// ----------------------------------------------------------------------------
// fme_post
// Back end: scales the exponential into a degree (a second division for the
// sigmoid shapes), applies the floor, selects per shape and forms the
// complement in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_post import fme_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [E_W-1:0]   e_in,
  input  wire side_t            side_in,
  output logic                  done,
  output logic [DEGREE_BITS-1:0] degree,
  output logic [DEGREE_BITS-1:0] complement,
  output logic                  in_support,
  output logic [1:0]            status
);

  logic                    vm;
  logic [E_W-1:0]          em;
  logic [PROD_W-1:0]       prodm;
  side_t                   sdm;
  logic                    vn;
  logic [NUM2_W-1:0]       num2;
  logic [DEN2_W-1:0]       den2;
  side_t                   sdn;
  side_t                   sdn_next;
  logic                    vd;
  logic [DEGREE_BITS-1:0]  q2;
  side_t                   sdd;
  logic                    vf;
  logic [DEGREE_BITS-1:0]  degf;
  logic                    supf;
  status_t                 statf;
  logic [DEGREE_BITS-1:0]  deg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm   <= 1'b0;
      vn   <= 1'b0;
      vf   <= 1'b0;
      done <= 1'b0;
    end else begin
      vm   <= in_valid;
      vn   <= vm;
      vf   <= vd;
      done <= vf;
    end
  end

  // Scale by the full-scale degree.
  always_ff @(posedge clk) begin
    em    <= e_in;
    prodm <= PROD_W'(e_in) * PROD_W'(DMAX);
    sdm   <= side_in;
  end

  // The rounded Gaussian degree rides along with the item.
  always_comb begin
    sdn_next           = sdm;
    sdn_next.gauss_deg = DEGREE_BITS'((prodm + (PROD_W'(1) << (ONE_SHIFT - 1))) >> ONE_SHIFT);
  end

  // Sigmoid division operands.
  always_ff @(posedge clk) begin
    den2 <= DEN2_W'(em) + DEN2_W'(ONE_Q30);
    num2 <= (sdm.ctl.neg ? ONE_DMAX : prodm) +
            NUM2_W'((DEN2_W'(em) + DEN2_W'(ONE_Q30)) >> 1);
    sdn  <= sdn_next;
  end

  fme_div #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN2_W),
    .Q_W   (DEGREE_BITS),
    .TAG_W ($bits(side_t))
  ) u_sig_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vn),
    .num       (num2),
    .den       (den2),
    .tag_in    (sdn),
    .out_valid (vd),
    .quo       (q2),
    .tag_out   (sdd)
  );

  // Select the degree for the shape; errors force zero.
  always_comb begin
    logic [DEGREE_BITS-1:0] sig;
    sig = floor_deg(q2);
    case (sdd.ctl.kind) inside
      SHAPE_LEFT, SHAPE_RIGHT, SHAPE_TRI: deg_next = sdd.ramp_deg;
      SHAPE_SIG:   deg_next = sig;
      SHAPE_RSIG:  deg_next = floor_deg(DMAX - sig);
      SHAPE_GAUSS: deg_next = floor_deg(sdd.gauss_deg);
      default:     deg_next = '0;
    endcase
    if (sdd.ctl.status != STAT_OK) begin
      deg_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    degf  <= deg_next;
    supf  <= sdd.ctl.sup;
    statf <= sdd.ctl.status;
  end

  // Output register with the fuzzy complement.
  always_ff @(posedge clk) begin
    degree     <= degf;
    complement <= (degf >= THRESH) ? NOT_LOW : DMAX - degf;
    in_support <= supf;
    status     <= statf;
  end

endmodule

`default_nettype wire

/* rtl/fuzzy_membership_eval.sv */
// ----------------------------------------------------------------------------
// fuzzy_membership_eval
// Throughput: one value per cycle; busy is always low and the receiver
// cannot stall. The depth comes from the two bit-per-stage dividers and the
// 24-stage exp(-1) multiplier chain.
// Reset clears all valid bits and restores the shape setup to a
// triangle over [0, 256].
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_membership_eval import fme_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_BITS-1:0]  x_value,
  output logic                               done,
  output logic [DEGREE_BITS-1:0]             degree,
  output logic [DEGREE_BITS-1:0]             complement,
  output logic                               in_support,
  output logic [1:0]                         status,
  input  wire logic                          wr_en,
  input  wire logic [1:0]                    wr_index,
  input  wire logic [VALUE_BITS-1:0]         wr_data
);

  shape_t                        shape_kind;
  logic signed [VALUE_BITS-1:0]  start_point;
  logic signed [VALUE_BITS-1:0]  end_point;

  logic               p_valid;
  logic [NUM1_W-1:0]  p_num;
  logic [DEN1_W-1:0]  p_den;
  side_t              p_side;
  logic               d_valid;
  logic [Q1_W-1:0]    d_quo;
  side_t              d_side;
  logic               x_valid;
  logic [E_W-1:0]     x_e;
  side_t              x_side;

  // The pipeline never holds off a transfer.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind  <= SHAPE_TRI;
      start_point <= '0;
      end_point   <= VALUE_BITS'(256);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SHAPE_KIND:  shape_kind  <= shape_t'(wr_data[2:0]);
        REG_START_POINT: start_point <= wr_data;
        REG_END_POINT:   end_point   <= wr_data;
        default: ;
      endcase
    end
  end

  fme_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .x_value     (x_value),
    .shape_kind  (shape_kind),
    .start_point (start_point),
    .end_point   (end_point),
    .out_valid   (p_valid),
    .num         (p_num),
    .den         (p_den),
    .side        (p_side)
  );

  fme_div #(
    .NUM_W (NUM1_W),
    .DEN_W (DEN1_W),
    .Q_W   (Q1_W),
    .TAG_W ($bits(side_t))
  ) u_main_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .num       (p_num),
    .den       (p_den),
    .tag_in    (p_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .tag_out   (d_side)
  );

  fme_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .quo       (d_quo),
    .side_in   (d_side),
    .out_valid (x_valid),
    .e_out     (x_e),
    .side_out  (x_side)
  );

  fme_post u_post (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (x_valid),
    .e_in       (x_e),
    .side_in    (x_side),
    .done       (done),
    .degree     (degree),
    .complement (complement),
    .in_support (in_support),
    .status     (status)
  );

endmodule

`default_nettype wire
